// ===== sv/alle_pkg.sv =====
// shared types and constants for the array linked list engine
// no dependencies; used by alle_ctrl, alle_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

  localparam int FIELD_W  = 11;
  localparam int VALUE_W  = 64;
  localparam int REQ_W    = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_BEFORE = 4'd0,
    REQ_INS_AFTER  = 4'd1,
    REQ_INS_FRONT  = 4'd2,
    REQ_INS_BACK   = 4'd3,
    REQ_DELETE     = 4'd4,
    REQ_VALUE_AT   = 4'd5,
    REQ_SLOT_AT    = 4'd6,
    REQ_INDEX_OF   = 4'd7,
    REQ_FIND       = 4'd8,
    REQ_CLEAR      = 4'd9
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_RD_POS     = 4'd1,
    OP_INS_CHK    = 4'd2,
    OP_INS_TAKE   = 4'd3,
    OP_INS_LINK   = 4'd4,
    OP_CHK_LIVE   = 4'd5,
    OP_UNLINK     = 4'd6,
    OP_FREE       = 4'd7,
    OP_IDX_CHK    = 4'd8,
    OP_WALK_START = 4'd9,
    OP_WALK_STEP  = 4'd10,
    OP_WALK_HIT   = 4'd11,
    OP_FIND_MISS  = 4'd12,
    OP_CLR        = 4'd13,
    OP_SWEEP      = 4'd14,
    OP_EMIT       = 4'd15
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             ins_fail;
    logic             live_fail;
    logic             idx_bad;
    logic             walk_hit;
    logic             walk_miss;
    logic             sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/alle_dp.sv =====
// datapath: slot table memories, list registers, walk pointer and result registers
// depends on alle_pkg; driven by alle_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module alle_dp #(
  parameter int CAPACITY = 1024
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire alle_pkg::dp_cmd_t           cmd_i,
  output alle_pkg::dp_stat_t               stat_o,
  input  wire  [alle_pkg::REQ_W-1:0]       req_type_i,
  input  wire  [alle_pkg::FIELD_W-1:0]     position_i,
  input  wire  [alle_pkg::VALUE_W-1:0]     data_value_i,
  output logic [alle_pkg::FIELD_W-1:0]     slot_out_o,
  output logic [alle_pkg::VALUE_W-1:0]     value_out_o,
  output logic [alle_pkg::FIELD_W-1:0]     index_out_o,
  output logic [alle_pkg::STATUS_W-1:0]    status_o,
  output logic [alle_pkg::FIELD_W-1:0]     element_count_o,
  output logic [alle_pkg::FIELD_W-1:0]     head_slot_o,
  output logic [alle_pkg::FIELD_W-1:0]     tail_slot_o
);

  localparam int SW    = $clog2(CAPACITY + 1);
  localparam int KW    = $clog2(CAPACITY + 2);
  localparam int Depth = CAPACITY + 1;
  localparam logic [SW-1:0] CapS = SW'(CAPACITY);

  typedef enum logic [2:0] {
    MODE_SOLO, MODE_FRONT, MODE_BACK, MODE_BEFORE, MODE_AFTER
  } ins_mode_e;

  logic [SW-1:0]                 nx_mem [Depth];
  logic [SW-1:0]                 pv_mem [Depth];
  logic [alle_pkg::VALUE_W-1:0]  vl_mem [Depth];
  logic                          us_mem [Depth];

  logic [SW-1:0] nx_rd_q, pv_rd_q;
  logic [alle_pkg::VALUE_W-1:0] vl_rd_q;
  logic us_rd_q;

  logic [SW-1:0] rd_addr;
  logic nx_we, pv_we, vl_we, us_we, us_wd;
  logic [SW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, vl_wa, us_wa;

  logic [alle_pkg::REQ_W-1:0]   req_q, req_d;
  logic [alle_pkg::FIELD_W-1:0] pos_q, pos_d;
  logic [alle_pkg::VALUE_W-1:0] val_q, val_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, size_q, size_d;
  logic flag_q, flag_d;
  logic [SW-1:0] cur_q, cur_d, pp_q, pp_d, nn_q, nn_d, ns_q, ns_d, sw_q, sw_d;
  logic [KW-1:0] k_q, k_d;
  ins_mode_e mode_q, mode_d, mode_sel;
  logic [SW-1:0] res_slot_q, res_slot_d;
  logic [KW-1:0] res_idx_q, res_idx_d;
  logic [alle_pkg::VALUE_W-1:0] res_val_q, res_val_d;
  alle_pkg::status_e res_st_q, res_st_d;
  logic [alle_pkg::FIELD_W-1:0] o_slot_q, o_slot_d, o_idx_q, o_idx_d;
  logic [alle_pkg::FIELD_W-1:0] o_cnt_q, o_cnt_d, o_head_q, o_head_d, o_tail_q, o_tail_d;
  logic [alle_pkg::VALUE_W-1:0] o_val_q, o_val_d;
  logic [alle_pkg::STATUS_W-1:0] o_st_q, o_st_d;

  logic [SW-1:0] pos_s, start_cur;
  logic pos_ok, live, empty, full, use_flag;

  assign pos_s     = SW'(pos_q);
  assign pos_ok    = (pos_q != '0) && (32'(pos_q) <= 32'(CAPACITY));
  assign live      = pos_ok && us_rd_q;
  assign empty     = (size_q == '0);
  assign full      = (size_q == CapS);
  assign use_flag  = flag_q && (req_q != alle_pkg::REQ_FIND);
  assign start_cur = use_flag ? pos_s : head_q;

  always_comb begin
    if (empty) begin
      mode_sel = MODE_SOLO;
    end else if (req_q == alle_pkg::REQ_INS_BEFORE) begin
      mode_sel = (pos_s == head_q) ? MODE_FRONT : MODE_BEFORE;
    end else if (req_q == alle_pkg::REQ_INS_AFTER) begin
      mode_sel = (pos_s == tail_q) ? MODE_BACK : MODE_AFTER;
    end else if (req_q == alle_pkg::REQ_INS_FRONT) begin
      mode_sel = MODE_FRONT;
    end else begin
      mode_sel = MODE_BACK;
    end
  end

  always_comb begin
    stat_o.req        = req_q;
    stat_o.ins_fail   = full || (!empty && (req_q == alle_pkg::REQ_INS_BEFORE ||
                        req_q == alle_pkg::REQ_INS_AFTER) && !live);
    stat_o.live_fail  = !live;
    stat_o.idx_bad    = (pos_q == '0) || (32'(pos_q) > 32'(size_q));
    stat_o.sweep_last = (sw_q == CapS);
    stat_o.walk_miss  = (req_q == alle_pkg::REQ_FIND) && (k_q > KW'(size_q));
    if (req_q == alle_pkg::REQ_INDEX_OF) begin
      stat_o.walk_hit = (cur_q == pos_s) || (k_q >= KW'(size_q));
    end else if (req_q == alle_pkg::REQ_FIND) begin
      stat_o.walk_hit = (vl_rd_q == val_q);
    end else begin
      stat_o.walk_hit = (k_q == KW'(pos_q));
    end
  end

  always_comb begin
    req_d = req_q; pos_d = pos_q; val_d = val_q;
    head_d = head_q; tail_d = tail_q; free_d = free_q; size_d = size_q;
    flag_d = flag_q; cur_d = cur_q; k_d = k_q; pp_d = pp_q; nn_d = nn_q;
    ns_d = ns_q; mode_d = mode_q; sw_d = sw_q;
    res_slot_d = res_slot_q; res_idx_d = res_idx_q; res_val_d = res_val_q;
    res_st_d = res_st_q;
    o_slot_d = o_slot_q; o_val_d = o_val_q; o_idx_d = o_idx_q; o_st_d = o_st_q;
    o_cnt_d = o_cnt_q; o_head_d = o_head_q; o_tail_d = o_tail_q;
    rd_addr = cur_q;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    vl_we = 1'b0; vl_wa = '0;
    us_we = 1'b0; us_wa = '0; us_wd = 1'b0;

    if (cmd_i.load) begin
      req_d      = req_type_i;
      pos_d      = position_i;
      val_d      = data_value_i;
      res_slot_d = '0;
      res_idx_d  = '0;
      res_val_d  = '0;
      res_st_d   = alle_pkg::ST_OK;
    end

    unique case (cmd_i.op)
      alle_pkg::OP_NONE: begin
      end
      alle_pkg::OP_RD_POS: begin
        rd_addr = pos_s;
      end
      alle_pkg::OP_INS_CHK: begin
        rd_addr = free_q;
        pp_d    = pv_rd_q;
        nn_d    = nx_rd_q;
        mode_d  = mode_sel;
        if (full) begin
          res_st_d = alle_pkg::ST_FULL;
        end else if (stat_o.ins_fail) begin
          res_st_d = alle_pkg::ST_BAD_POS;
        end
      end
      alle_pkg::OP_INS_TAKE: begin
        ns_d       = free_q;
        res_slot_d = free_q;
        free_d     = nx_rd_q;
        size_d     = size_q + SW'(1);
        vl_we = 1'b1; vl_wa = free_q;
        us_we = 1'b1; us_wa = free_q; us_wd = 1'b1;
        nx_we = 1'b1; nx_wa = free_q;
        pv_we = 1'b1; pv_wa = free_q;
        case (mode_q)
          MODE_FRONT:  begin nx_wd = head_q; pv_wd = '0;     end
          MODE_BACK:   begin nx_wd = '0;     pv_wd = tail_q; end
          MODE_BEFORE: begin nx_wd = pos_s;  pv_wd = pp_q;   end
          MODE_AFTER:  begin nx_wd = nn_q;   pv_wd = pos_s;  end
          default:     begin nx_wd = '0;     pv_wd = '0;     end
        endcase
      end
      alle_pkg::OP_INS_LINK: begin
        case (mode_q)
          MODE_FRONT: begin
            pv_we = 1'b1; pv_wa = head_q; pv_wd = ns_q;
            head_d = ns_q; flag_d = 1'b0;
          end
          MODE_BACK: begin
            nx_we = 1'b1; nx_wa = tail_q; nx_wd = ns_q;
            tail_d = ns_q;
          end
          MODE_BEFORE: begin
            nx_we = 1'b1; nx_wa = pp_q;  nx_wd = ns_q;
            pv_we = 1'b1; pv_wa = pos_s; pv_wd = ns_q;
            flag_d = 1'b0;
          end
          MODE_AFTER: begin
            pv_we = 1'b1; pv_wa = nn_q;  pv_wd = ns_q;
            nx_we = 1'b1; nx_wa = pos_s; nx_wd = ns_q;
            flag_d = 1'b0;
          end
          default: begin
            head_d = ns_q; tail_d = ns_q;
          end
        endcase
      end
      alle_pkg::OP_CHK_LIVE: begin
        pp_d = pv_rd_q;
        nn_d = nx_rd_q;
        if (!live) begin
          res_st_d = alle_pkg::ST_BAD_POS;
        end
      end
      alle_pkg::OP_UNLINK: begin
        if (pos_s != tail_q) begin
          flag_d = 1'b0;
        end
        if (size_q <= SW'(1)) begin
          head_d = '0; tail_d = '0;
        end else if (pos_s == head_q) begin
          head_d = nn_q;
          pv_we = 1'b1; pv_wa = nn_q; pv_wd = '0;
        end else if (pos_s == tail_q) begin
          tail_d = pp_q;
          nx_we = 1'b1; nx_wa = pp_q; nx_wd = '0;
        end else begin
          nx_we = 1'b1; nx_wa = pp_q; nx_wd = nn_q;
          pv_we = 1'b1; pv_wa = nn_q; pv_wd = pp_q;
        end
      end
      alle_pkg::OP_FREE: begin
        nx_we = 1'b1; nx_wa = pos_s; nx_wd = free_q;
        pv_we = 1'b1; pv_wa = pos_s; pv_wd = '0;
        us_we = 1'b1; us_wa = pos_s; us_wd = 1'b0;
        free_d     = pos_s;
        size_d     = size_q - SW'(1);
        res_slot_d = pos_s;
      end
      alle_pkg::OP_IDX_CHK: begin
        if (stat_o.idx_bad) begin
          res_st_d = alle_pkg::ST_BAD_POS;
        end
      end
      alle_pkg::OP_WALK_START: begin
        rd_addr = start_cur;
        cur_d   = start_cur;
        k_d     = use_flag ? KW'(pos_q) : KW'(1);
      end
      alle_pkg::OP_WALK_STEP: begin
        rd_addr = nx_rd_q;
        cur_d   = nx_rd_q;
        k_d     = k_q + KW'(1);
      end
      alle_pkg::OP_WALK_HIT: begin
        res_slot_d = (req_q == alle_pkg::REQ_INDEX_OF) ? pos_s : cur_q;
        if (req_q == alle_pkg::REQ_VALUE_AT) begin
          res_val_d = vl_rd_q;
        end
        if (req_q == alle_pkg::REQ_INDEX_OF) begin
          res_idx_d = k_q;
        end
      end
      alle_pkg::OP_FIND_MISS: begin
        res_st_d = alle_pkg::ST_NOT_FOUND;
      end
      alle_pkg::OP_CLR: begin
        head_d = '0; tail_d = '0; free_d = SW'(1); size_d = '0;
        flag_d = 1'b1; sw_d = '0;
      end
      alle_pkg::OP_SWEEP: begin
        nx_we = 1'b1; nx_wa = sw_q;
        nx_wd = (sw_q != '0 && sw_q < CapS) ? sw_q + SW'(1) : '0;
        pv_we = 1'b1; pv_wa = sw_q; pv_wd = '0;
        us_we = 1'b1; us_wa = sw_q; us_wd = 1'b0;
        sw_d  = sw_q + SW'(1);
      end
      alle_pkg::OP_EMIT: begin
        o_slot_d = alle_pkg::FIELD_W'(res_slot_q);
        o_val_d  = res_val_q;
        o_idx_d  = alle_pkg::FIELD_W'(res_idx_q);
        o_st_d   = res_st_q;
        o_cnt_d  = alle_pkg::FIELD_W'(size_q);
        o_head_d = alle_pkg::FIELD_W'(head_q);
        o_tail_d = alle_pkg::FIELD_W'(tail_q);
      end
      default: begin
      end
    endcase
  end

  // slot table: one shared read address, registered read data
  always_ff @(posedge clk_i) begin
    nx_rd_q <= nx_mem[rd_addr];
    pv_rd_q <= pv_mem[rd_addr];
    vl_rd_q <= vl_mem[rd_addr];
    us_rd_q <= us_mem[rd_addr];
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (vl_we) vl_mem[vl_wa] <= val_q;
    if (us_we) us_mem[us_wa] <= us_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      free_q <= SW'(1);
      size_q <= '0;
      flag_q <= 1'b1;
      sw_q   <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      size_q <= size_d;
      flag_q <= flag_d;
      sw_q   <= sw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; pos_q <= pos_d; val_q <= val_d;
    cur_q <= cur_d; k_q <= k_d; pp_q <= pp_d; nn_q <= nn_d; ns_q <= ns_d;
    mode_q <= mode_d;
    res_slot_q <= res_slot_d; res_idx_q <= res_idx_d;
    res_val_q <= res_val_d; res_st_q <= res_st_d;
    o_slot_q <= o_slot_d; o_val_q <= o_val_d; o_idx_q <= o_idx_d; o_st_q <= o_st_d;
    o_cnt_q <= o_cnt_d; o_head_q <= o_head_d; o_tail_q <= o_tail_d;
  end

  assign slot_out_o      = o_slot_q;
  assign value_out_o     = o_val_q;
  assign index_out_o     = o_idx_q;
  assign status_o        = o_st_q;
  assign element_count_o = o_cnt_q;
  assign head_slot_o     = o_head_q;
  assign tail_slot_o     = o_tail_q;

`ifndef SYNTHESIS
  // a free slot always exists unless the table is full
  a_free_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q != CapS) |-> (free_q != '0))
    else $error("free chain empty while table not full");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == alle_pkg::OP_INS_TAKE) |-> (size_q < CapS))
    else $error("slot taken from a full table");
`endif

endmodule

`default_nettype wire

// ===== sv/alle_ctrl.sv =====
// controller state machine sequencing table reads, writes and walks
// depends on alle_pkg; commands alle_dp through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module alle_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  wire alle_pkg::dp_stat_t stat_i,
  output alle_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DECODE  = 16'h0002,
    S_RDPOS   = 16'h0004,
    S_INSCHK  = 16'h0008,
    S_TAKE    = 16'h0010,
    S_LINK    = 16'h0020,
    S_LIVECHK = 16'h0040,
    S_UNLINK  = 16'h0080,
    S_FREE    = 16'h0100,
    S_IDXCHK  = 16'h0200,
    S_WSTART  = 16'h0400,
    S_WALK    = 16'h0800,
    S_CLR     = 16'h1000,
    S_CSWEEP  = 16'h2000,
    S_RSWEEP  = 16'h4000,
    S_EMIT    = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = accept;
    cmd_o.op    = alle_pkg::OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.req) inside
          alle_pkg::REQ_INS_BEFORE, alle_pkg::REQ_INS_AFTER, alle_pkg::REQ_INS_FRONT,
          alle_pkg::REQ_INS_BACK, alle_pkg::REQ_DELETE, alle_pkg::REQ_INDEX_OF:
            state_d = S_RDPOS;
          alle_pkg::REQ_VALUE_AT, alle_pkg::REQ_SLOT_AT: state_d = S_IDXCHK;
          alle_pkg::REQ_FIND:  state_d = S_WSTART;
          alle_pkg::REQ_CLEAR: state_d = S_CLR;
          default:             state_d = S_EMIT;
        endcase
      end
      S_RDPOS: begin
        cmd_o.op = alle_pkg::OP_RD_POS;
        if (stat_i.req == alle_pkg::REQ_DELETE || stat_i.req == alle_pkg::REQ_INDEX_OF) begin
          state_d = S_LIVECHK;
        end else begin
          state_d = S_INSCHK;
        end
      end
      S_INSCHK: begin
        cmd_o.op = alle_pkg::OP_INS_CHK;
        state_d  = stat_i.ins_fail ? S_EMIT : S_TAKE;
      end
      S_TAKE: begin
        cmd_o.op = alle_pkg::OP_INS_TAKE;
        state_d  = S_LINK;
      end
      S_LINK: begin
        cmd_o.op = alle_pkg::OP_INS_LINK;
        state_d  = S_EMIT;
      end
      S_LIVECHK: begin
        cmd_o.op = alle_pkg::OP_CHK_LIVE;
        if (stat_i.live_fail) begin
          state_d = S_EMIT;
        end else if (stat_i.req == alle_pkg::REQ_DELETE) begin
          state_d = S_UNLINK;
        end else begin
          state_d = S_WSTART;
        end
      end
      S_UNLINK: begin
        cmd_o.op = alle_pkg::OP_UNLINK;
        state_d  = S_FREE;
      end
      S_FREE: begin
        cmd_o.op = alle_pkg::OP_FREE;
        state_d  = S_EMIT;
      end
      S_IDXCHK: begin
        cmd_o.op = alle_pkg::OP_IDX_CHK;
        state_d  = stat_i.idx_bad ? S_EMIT : S_WSTART;
      end
      S_WSTART: begin
        cmd_o.op = alle_pkg::OP_WALK_START;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_miss) begin
          cmd_o.op = alle_pkg::OP_FIND_MISS;
          state_d  = S_EMIT;
        end else if (stat_i.walk_hit) begin
          cmd_o.op = alle_pkg::OP_WALK_HIT;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = alle_pkg::OP_WALK_STEP;
        end
      end
      S_CLR: begin
        cmd_o.op = alle_pkg::OP_CLR;
        state_d  = S_CSWEEP;
      end
      S_CSWEEP: begin
        cmd_o.op = alle_pkg::OP_SWEEP;
        if (stat_i.sweep_last) state_d = S_EMIT;
      end
      S_RSWEEP: begin
        cmd_o.op = alle_pkg::OP_SWEEP;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = alle_pkg::OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RSWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result shown without an emit step");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");
`endif

endmodule

`default_nettype wire

// ===== sv/array_linked_list_engine_core.sv =====
// top level of the array linked list engine: controller plus datapath
// depends on alle_pkg, alle_ctrl and alle_dp
`timescale 1ns / 1ps
`default_nettype none

// usage
//   requests enter on in_valid_i / in_stall_o with req_type_i, position_i and data_value_i;
//   one result per request leaves on out_valid_o / out_stall_i
//   a transfer happens on a clock edge with valid high and stall low
// sequence, one request at a time: inserts decode, read position, check, take a slot, link
//   and emit; deletes decode, read position, check liveness, unlink, free and emit;
//   a bad or full answer is emitted after its check, an unused request code after decode
//   value_at / slot_at and index_of start the walk at slot position_i when the list is in
//     slot order, otherwise at the head; find compares from the head to a match or the end
//   clear resets the list registers, then rewrites the slot table one slot per cycle
//   the walk follows one link per cycle through the single read port of the slot table
// reset: the block first sweeps every slot of the table with in_stall_o high,
//   rebuilding the free chain; no result is produced for that sweep
// the output register holds a result until it is taken; a new request can be
//   accepted meanwhile, but its result waits while the receiver stalls
module array_linked_list_engine_core #(
  parameter int CAPACITY = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [alle_pkg::REQ_W-1:0]        req_type_i,
  input  wire  [alle_pkg::FIELD_W-1:0]      position_i,
  input  wire  [alle_pkg::VALUE_W-1:0]      data_value_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [alle_pkg::FIELD_W-1:0]      slot_out_o,
  output logic [alle_pkg::VALUE_W-1:0]      value_out_o,
  output logic [alle_pkg::FIELD_W-1:0]      index_out_o,
  output logic [alle_pkg::STATUS_W-1:0]     status_o,
  output logic [alle_pkg::FIELD_W-1:0]      element_count_o,
  output logic [alle_pkg::FIELD_W-1:0]      head_slot_o,
  output logic [alle_pkg::FIELD_W-1:0]      tail_slot_o
);

  // command and status between sequencer and datapath
  alle_pkg::dp_cmd_t  cmd;
  alle_pkg::dp_stat_t stat;

  alle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // slot table, list registers and output register
  alle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_type_i),
    .position_i      (position_i),
    .data_value_i    (data_value_i),
    .slot_out_o      (slot_out_o),
    .value_out_o     (value_out_o),
    .index_out_o     (index_out_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .head_slot_o     (head_slot_o),
    .tail_slot_o     (tail_slot_o)
  );

endmodule

`default_nettype wire

// ===== bench/array_linked_list_engine_core_checker.sv =====
// checker for the array linked list engine: watches both channels, predicts, compares
// depends on alle_pkg; instantiated beside the block by array_linked_list_engine_core_tb
`timescale 1ns / 1ps

module array_linked_list_engine_core_checker #(
  parameter int CAPACITY = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire  [3:0]  req_type_i,
  input  wire  [10:0] position_i,
  input  wire  [63:0] data_value_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire  [10:0] slot_out_i,
  input  wire  [63:0] value_out_i,
  input  wire  [10:0] index_out_i,
  input  wire  [1:0]  status_i,
  input  wire  [10:0] element_count_i,
  input  wire  [10:0] head_slot_i,
  input  wire  [10:0] tail_slot_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          list_len_o
);

  typedef struct {
    logic [10:0] slot;
    logic [63:0] value;
    logic [10:0] index;
    logic [1:0]  status;
    logic [10:0] count;
    logic [10:0] head;
    logic [10:0] tail;
  } answer_t;

  answer_t     answers_q[$];
  logic [63:0] vals[CAPACITY+1];
  logic [10:0] nxt[CAPACITY+1];
  logic [10:0] prv[CAPACITY+1];
  bit          used[CAPACITY+1];
  logic [10:0] head, tail, free_top, len;
  bit          ordered;

  function automatic logic [10:0] clip(logic [10:0] s);
    return (s <= CAPACITY) ? s : 11'd0;
  endfunction

  function automatic bit is_live(logic [10:0] s);
    return s >= 1 && s <= CAPACITY && used[s];
  endfunction

  function automatic void rebuild_list();
    for (int i = 0; i <= CAPACITY; i++) begin
      nxt[i] = (i >= 1 && i < CAPACITY) ? 11'(i + 1) : 11'd0;
      prv[i] = 0;
      used[i] = 0;
    end
    head = 0; tail = 0; free_top = 1; len = 0; ordered = 1;
  endfunction

  function automatic logic [10:0] grab_slot(logic [63:0] v);
    logic [10:0] n;
    n = clip(free_top);
    free_top = clip(nxt[n]);
    vals[n] = v;
    used[n] = 1;
    len++;
    return n;
  endfunction

  function automatic answer_t apply_request(logic [3:0] rq, logic [10:0] pos, logic [63:0] v);
    answer_t     a;
    logic [10:0] s, p, n, cur;
    int          k;
    a = '{default: '0};
    if (rq <= alle_pkg::REQ_INS_BACK) begin
      if (len >= CAPACITY) a.status = alle_pkg::ST_FULL;
      else if (len == 0) begin
        s = grab_slot(v);
        prv[s] = 0; nxt[s] = 0; head = s; tail = s; a.slot = s;
      end else if (rq <= alle_pkg::REQ_INS_AFTER && !is_live(pos)) begin
        a.status = alle_pkg::ST_BAD_POS;
      end else begin
        if (rq == alle_pkg::REQ_INS_BEFORE && pos == head) rq = alle_pkg::REQ_INS_FRONT;
        if (rq == alle_pkg::REQ_INS_AFTER && pos == tail) rq = alle_pkg::REQ_INS_BACK;
        s = grab_slot(v);
        a.slot = s;
        case (rq)
          alle_pkg::REQ_INS_FRONT: begin
            prv[s] = 0; nxt[s] = head; prv[clip(head)] = s; head = s; ordered = 0;
          end
          alle_pkg::REQ_INS_BACK: begin
            prv[s] = tail; nxt[s] = 0; nxt[clip(tail)] = s; tail = s;
          end
          alle_pkg::REQ_INS_BEFORE: begin
            p = clip(prv[pos]);
            prv[s] = p; nxt[p] = s; nxt[s] = pos; prv[pos] = s; ordered = 0;
          end
          default: begin
            n = clip(nxt[pos]);
            nxt[s] = n; prv[n] = s; prv[s] = pos; nxt[pos] = s; ordered = 0;
          end
        endcase
      end
    end else if (rq == alle_pkg::REQ_DELETE) begin
      if (!is_live(pos)) a.status = alle_pkg::ST_BAD_POS;
      else begin
        p = clip(prv[pos]);
        n = clip(nxt[pos]);
        if (pos != tail) ordered = 0;
        if (len <= 1) begin
          head = 0; tail = 0;
        end else if (pos == head) begin
          head = n; prv[n] = 0;
        end else if (pos == tail) begin
          tail = p; nxt[p] = 0;
        end else begin
          nxt[p] = n; prv[n] = p;
        end
        nxt[pos] = free_top; prv[pos] = 0; used[pos] = 0; free_top = pos;
        len--;
        a.slot = pos;
      end
    end else if (rq == alle_pkg::REQ_VALUE_AT || rq == alle_pkg::REQ_SLOT_AT) begin
      if (pos == 0 || pos > len) a.status = alle_pkg::ST_BAD_POS;
      else begin
        if (ordered) cur = pos;
        else begin
          cur = clip(head);
          for (int i = 1; i < pos; i++) cur = clip(nxt[cur]);
        end
        a.slot = clip(cur);
        if (rq == alle_pkg::REQ_VALUE_AT) a.value = vals[a.slot];
      end
    end else if (rq == alle_pkg::REQ_INDEX_OF) begin
      if (!is_live(pos)) a.status = alle_pkg::ST_BAD_POS;
      else if (ordered) begin
        a.index = pos; a.slot = pos;
      end else begin
        cur = clip(head); k = 1;
        while (cur != pos && k < len) begin
          cur = clip(nxt[cur]); k++;
        end
        a.index = 11'(k); a.slot = pos;
      end
    end else if (rq == alle_pkg::REQ_FIND) begin
      cur = clip(head);
      a.status = alle_pkg::ST_NOT_FOUND;
      for (int i = 1; i <= len; i++) begin
        if (vals[cur] == v) begin
          a.slot = cur; a.status = alle_pkg::ST_OK;
          break;
        end
        cur = clip(nxt[cur]);
      end
    end else if (rq == alle_pkg::REQ_CLEAR) rebuild_list();
    a.count = len; a.head = head; a.tail = tail;
    return a;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i <= CAPACITY; i++) vals[i] = '0;
    rebuild_list();
  end

  assign pending_o  = answers_q.size();
  assign list_len_o = len;

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (answers_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count_o++;
      end else begin
        want = answers_q.pop_front();
        compare_field("slot_out", want.slot, slot_out_i);
        compare_field("value_out", want.value, value_out_i);
        compare_field("index_out", want.index, index_out_i);
        compare_field("status", want.status, status_i);
        compare_field("element_count", want.count, element_count_i);
        compare_field("head_slot", want.head, head_slot_i);
        compare_field("tail_slot", want.tail, tail_slot_i);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_i)
      answers_q.push_back(apply_request(req_type_i, position_i, data_value_i));
  end
endmodule

// ===== bench/array_linked_list_engine_core_tb.sv =====
// testbench top for array_linked_list_engine_core: clock, reset, request stimulus, verdict
// depends on alle_pkg, the block and array_linked_list_engine_core_checker
`timescale 1ns / 1ps

module array_linked_list_engine_core_tb;

  localparam int CAP = 1024;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic [3:0]  req_type_i = '0;
  logic [10:0] position_i = '0;
  logic [63:0] data_value_i = '0;
  logic        out_stall_i = 0;
  wire         in_stall_o, out_valid_o;
  wire  [10:0] slot_out_o, index_out_o, element_count_o, head_slot_o, tail_slot_o;
  wire  [63:0] value_out_o;
  wire  [1:0]  status_o;
  int          fail_count, pending, list_len;
  int          sent_total, clears_sent;
  logic [63:0] recent_values[8];
  bit          valid_on = 0;

  always #5 clk_i = ~clk_i;

  array_linked_list_engine_core #(.CAPACITY(CAP)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .position_i, .data_value_i,
    .out_valid_o, .out_stall_i, .slot_out_o, .value_out_o, .index_out_o, .status_o,
    .element_count_o, .head_slot_o, .tail_slot_o
  );

  array_linked_list_engine_core_checker #(.CAPACITY(CAP)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .position_i,
    .data_value_i, .out_valid_i(out_valid_o), .out_stall_i, .slot_out_i(slot_out_o),
    .value_out_i(value_out_o), .index_out_i(index_out_o), .status_i(status_o),
    .element_count_i(element_count_o), .head_slot_i(head_slot_o),
    .tail_slot_i(tail_slot_o), .fail_count_o(fail_count), .pending_o(pending),
    .list_len_o(list_len)
  );

  // one request transfer; random idle gap first, stalls waited out
  // valid stays up after a transfer so that a request with no gap follows directly
  task automatic send_request(alle_pkg::req_e rq, logic [10:0] pos, logic [63:0] v,
                              bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      if (valid_on) begin
        in_valid_i <= 0;
        valid_on = 0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1;
    valid_on     = 1;
    req_type_i   <= rq;
    position_i   <= pos;
    data_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    recent_values[sent_total % 8] = v;
    sent_total++;
    if (rq == alle_pkg::REQ_CLEAR) clears_sent++;
  endtask

  task automatic drain();
    if (valid_on) begin
      in_valid_i <= 0;
      valid_on = 0;
    end
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [63:0] any_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return recent_values[$urandom_range(0, 7)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // slot numbers: mostly small and plausibly live, some out of range or zero
  function automatic logic [10:0] any_slot();
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'($urandom_range(CAP + 1, 2047));
      2:       return 11'($urandom_range(1, CAP));
      default: return 11'($urandom_range(1, list_len + 4));
    endcase
  endfunction

  function automatic logic [10:0] any_index();
    case ($urandom_range(0, 7))
      0:       return 11'd0;
      1:       return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(1, list_len + 1));
    endcase
  endfunction

  // receiver stall: per result a random hold, with calm stretches
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16);
        if (hold != 0) begin
          out_stall_i <= 1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 0;
        end
      end
    end
  end

  initial begin
    int rq_pick;
    sent_total = 0;
    clears_sent = 0;
    for (int i = 0; i < 8; i++) recent_values[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // directed: empty list corners, then each request kind and the field extremes
    send_request(alle_pkg::REQ_VALUE_AT, 11'd1, '0);
    send_request(alle_pkg::REQ_FIND, 11'd0, '0);
    send_request(alle_pkg::REQ_DELETE, 11'd1, '0);
    send_request(alle_pkg::REQ_INS_BEFORE, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(alle_pkg::REQ_INS_BACK, 11'd0, 64'h0);
    send_request(alle_pkg::REQ_INS_BACK, 11'd1024, 64'h0123_4567_89AB_CDEF);
    send_request(alle_pkg::REQ_INDEX_OF, 11'd3, '0);
    send_request(alle_pkg::REQ_VALUE_AT, 11'd3, '0);
    send_request(alle_pkg::REQ_SLOT_AT, 11'd4, '0);
    send_request(alle_pkg::REQ_DELETE, 11'd3, '0);
    send_request(alle_pkg::REQ_INS_AFTER, 11'd1, 64'hAAAA_5555_AAAA_5555);
    send_request(alle_pkg::REQ_INS_BEFORE, 11'd1, 64'h5555_AAAA_5555_AAAA);
    send_request(alle_pkg::REQ_INS_BEFORE, 11'd3, 64'h77);
    send_request(alle_pkg::REQ_INS_AFTER, 11'd0, 64'h1);
    send_request(alle_pkg::REQ_INS_AFTER, 11'd1025, 64'h1);
    send_request(alle_pkg::REQ_INS_FRONT, 11'd0, 64'h8000_0000_0000_0000);
    send_request(alle_pkg::REQ_INDEX_OF, 11'd2, '0);
    send_request(alle_pkg::REQ_VALUE_AT, 11'd2, '0);
    send_request(alle_pkg::REQ_FIND, 11'd0, 64'h77);
    send_request(alle_pkg::REQ_FIND, 11'd0, 64'hDEAD);
    send_request(alle_pkg::REQ_DELETE, 11'd1, '0);
    send_request(alle_pkg::req_e'(4'd15), 11'h7FF, '1);
    send_request(alle_pkg::REQ_CLEAR, 11'd0, '0);
    drain();

    // fill the table to capacity, hit table full, then walk-heavy lookups at the extreme
    for (int i = 0; i < CAP; i++) begin
      send_request(alle_pkg::REQ_INS_BACK, 11'd0, {$urandom, $urandom}, 1);
    end
    send_request(alle_pkg::REQ_INS_FRONT, 11'd0, '1);
    send_request(alle_pkg::REQ_INS_AFTER, 11'd5, '1);
    send_request(alle_pkg::REQ_VALUE_AT, 11'd1024, '0);
    send_request(alle_pkg::REQ_INS_BACK, 11'd0, '0);
    send_request(alle_pkg::REQ_DELETE, 11'd1, '0);
    send_request(alle_pkg::REQ_INS_FRONT, 11'd0, 64'h42);
    send_request(alle_pkg::REQ_SLOT_AT, 11'd1024, '0);
    send_request(alle_pkg::REQ_INDEX_OF, 11'd1024, '0);
    send_request(alle_pkg::REQ_FIND, 11'd0, 64'hFEED);
    send_request(alle_pkg::REQ_CLEAR, 11'd0, '0);
    drain();

    // random mix on a small list so walks stay short; occasional clear
    while (sent_total < 1950) begin
      rq_pick = $urandom_range(0, 99);
      if (rq_pick < 40 && list_len < 60) begin
        send_request(alle_pkg::req_e'($urandom_range(0, 3)), any_slot(), any_value());
      end else if (rq_pick < 58) begin
        send_request(alle_pkg::REQ_DELETE, any_slot(), '0);
      end else if (rq_pick < 92) begin
        send_request(alle_pkg::req_e'($urandom_range(5, 6)),
          ($urandom_range(0, 1) != 0) ? any_index() : any_slot(), any_value());
        send_request(alle_pkg::REQ_INDEX_OF, any_slot(), '0);
        send_request(alle_pkg::REQ_FIND, any_slot(), any_value());
      end else if (rq_pick < 94) begin
        send_request(alle_pkg::REQ_CLEAR, 11'($urandom_range(0, 2047)), any_value());
        drain();
      end else if (rq_pick < 96) begin
        send_request(alle_pkg::req_e'($urandom_range(10, 15)),
          11'($urandom_range(0, 2047)), '1);
      end else begin
        // sender holds off until the block has answered everything
        drain();
      end
    end

    drain();
    repeat (CAP + 50) @(posedge clk_i);
    $display("covered %0d requests incl. %0d clears, fill to capacity and table-full inserts",
             sent_total, clears_sent);
    if (fail_count == 0 && pending == 0) $display("array_linked_list_engine_core_tb: clean");
    else $display("array_linked_list_engine_core_tb: errors");
    $finish;
  end

  initial begin
    #200ms;
    $display("array_linked_list_engine_core_tb: errors");
    $finish;
  end
endmodule
